### src/bsws_pkg.sv
// Package of the bounded stack with search: command and status codes,
// the result record and default sizes. Depends on nothing.
`default_nettype none
package bsws_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int WORD_W    = 32;
  localparam int INDEX_W   = 5;
  localparam int COUNT_W   = 6;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    status_t                    status;
    logic signed [WORD_W-1:0]   data;
    logic [INDEX_W-1:0]         index;
    logic [COUNT_W-1:0]         count;
    logic                       full;
    logic                       empty;
  } res_t;

endpackage
`default_nettype wire

### src/bsws_in_if.sv
// Command channel of the bounded stack with search: valid, ready and
// one command beat. Depends on nothing.
`default_nettype none
interface bsws_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface
`default_nettype wire

### src/bsws_out_if.sv
// Result channel of the bounded stack with search: valid, ready and
// one result beat. Depends on nothing.
`default_nettype none
interface bsws_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic [4:0]         index;
  logic [5:0]         count;
  logic               full_res;
  logic               empty_res;

  modport source (output valid, output status, output data, output index,
                  output count, output full_res, output empty_res, input ready);
  modport sink (input valid, input status, input data, input index,
                input count, input full_res, input empty_res, output ready);
endinterface
`default_nettype wire

### src/bounded_stack_with_search_unit.sv
// Bounded LIFO stack of signed 32-bit words with a linear search by key.
// Users: commands arrive as beats on req (command, value); every command
// returns exactly one beat on rsp (status, data, index, count, full_res,
// empty_res), in command order.
// Push and pop complete in the cycle they are taken; peek waits for the
// RAM read, and a search reads stored words until a match or the top. The
// stack lives in a single RAM with a registered read, and the search reads
// it one word per cycle from the bottom up. One command is worked on at a
// time. A result is registered in the output buffer before it reaches rsp.
// The result path has an output register and a skid stage, so the next
// command is taken while one result waits on a stalled receiver; with two
// results waiting, req.ready stays low until rsp drains.
// Reset (rst, synchronous) empties the stack and drops any waiting results;
// RAM contents are not cleared, and no entry at or above the count is read.
// Depends on bsws_pkg, bsws_in_if, bsws_out_if, bsws_ram, bsws_seq, bsws_obuf.
`default_nettype none
module bounded_stack_with_search_unit #(
  parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  bsws_in_if.sink   req,
  bsws_out_if.source rsp
);
  import bsws_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  bsws_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  bsws_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  bsws_obuf u_obuf (
    .clk     (clk),
    .rst     (rst),
    .in_valid(res_valid),
    .in_ready(res_ready),
    .in_res  (res),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire

### src/bsws_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none
module bsws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/bsws_seq.sv
// Command sequencer: holds the word count, drives the stack RAM and walks
// it for a search. Depends on bsws_pkg, bsws_in_if and bsws_ram's ports.
`default_nettype none
module bsws_seq #(
  parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  bsws_in_if.sink                         req,
  output logic                            mem_we,
  output logic [$clog2(DEPTH)-1:0]        mem_waddr,
  output logic [bsws_pkg::WORD_W-1:0]     mem_wdata,
  output logic                            mem_re,
  output logic [$clog2(DEPTH)-1:0]        mem_raddr,
  input  wire logic [bsws_pkg::WORD_W-1:0] mem_rdata,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output bsws_pkg::res_t                  res
);
  import bsws_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PEEK = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     ptr, ptr_next;
  logic [WORD_W-1:0] key, key_next;
  logic              accept;
  logic [CW-1:0]     top_idx;
  logic [CW-1:0]     ptr_inc;
  cmd_t              cmd;

  assign req.ready = (state == S_IDLE) && res_ready;
  assign accept    = req.valid && req.ready;
  assign cmd       = cmd_t'(req.command);
  assign top_idx   = count - CW'(1);
  assign ptr_inc   = CW'(ptr) + CW'(1);

  always_comb begin
    state_next = state;
    count_next = count;
    ptr_next   = ptr;
    key_next   = key;
    mem_we     = 1'b0;
    mem_waddr  = count[AW-1:0];
    mem_wdata  = req.value;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    res_valid  = 1'b0;
    res.status = ST_OK;
    res.data   = '0;
    res.index  = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_PUSH: begin
              res_valid = 1'b1;
              if (count == FULL_CNT) begin
                res.status = ST_OVERFLOW;
              end else begin
                mem_we     = 1'b1;
                count_next = count + CW'(1);
              end
            end
            CMD_POP: begin
              res_valid = 1'b1;
              if (count == '0) begin
                res.status = ST_UNDERFLOW;
              end else begin
                count_next = top_idx;
              end
            end
            CMD_PEEK: begin
              if (count == '0) begin
                res_valid  = 1'b1;
                res.status = ST_UNDERFLOW;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = top_idx[AW-1:0];
                state_next = S_PEEK;
              end
            end
            CMD_SEARCH: begin
              if (count == '0) begin
                res_valid  = 1'b1;
                res.status = ST_NOT_FOUND;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                ptr_next   = '0;
                key_next   = req.value;
                state_next = S_SCAN;
              end
            end
            default: begin
              res_valid = 1'b0;
            end
          endcase
        end
      end
      S_PEEK: begin
        res_valid = 1'b1;
        res.data  = mem_rdata;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        priority if (mem_rdata == key) begin
          res_valid  = 1'b1;
          res.data   = key;
          res.index  = INDEX_W'(ptr);
          if (res_ready) begin
            state_next = S_IDLE;
          end
        end else if (ptr_inc == count) begin
          res_valid  = 1'b1;
          res.status = ST_NOT_FOUND;
          if (res_ready) begin
            state_next = S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr + AW'(1);
          ptr_next  = ptr + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.count = COUNT_W'(count_next);
    res.full  = (count_next == FULL_CNT);
    res.empty = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    ptr <= ptr_next;
    key <= key_next;
  end

endmodule
`default_nettype wire

### src/bsws_obuf.sv
// Output register with a skid stage for the result channel.
// Depends on bsws_pkg and bsws_out_if.
`default_nettype none
module bsws_obuf (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire bsws_pkg::res_t  in_res,
  bsws_out_if.source           rsp
);
  import bsws_pkg::*;

  logic out_valid;
  res_t out_q;
  logic skid_valid;
  res_t skid_q;
  logic in_fire;
  logic drain;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign drain    = rsp.ready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_q <= skid_valid ? skid_q : in_res;
    end else if (in_fire) begin
      skid_q <= in_res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_q.status;
  assign rsp.data      = out_q.data;
  assign rsp.index     = out_q.index;
  assign rsp.count     = out_q.count;
  assign rsp.full_res  = out_q.full;
  assign rsp.empty_res = out_q.empty;

endmodule
`default_nettype wire

### dv/bounded_stack_with_search_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounded_stack_with_search_unit: command beats with random gaps,
// results checked against a built-in stack predictor under random receiver stalls.
// Depends on bsws_pkg, bsws_in_if, bsws_out_if and the unit itself.
module bounded_stack_with_search_unit_test;
  import bsws_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int RANDOM_CMDS = 750;
  localparam int LONG_HOLD = 200;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS = 10;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  typedef struct {
    cmd_t               cmd;
    logic signed [31:0] value;
    int                 gap;
  } stack_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bsws_in_if  req_if ();
  bsws_out_if rsp_if ();

  bounded_stack_with_search_unit #(.DEPTH(STACK_DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  stack_cmd_t         pending_cmds[$];
  res_t               expected_results[$];
  logic signed [31:0] gen_words[$];
  logic signed [31:0] model_words[STACK_DEPTH];
  int                 model_count = 0;
  int                 idle_left = 0;
  int                 recv_wait = 0;
  int                 hold_left = 0;
  int                 next_hold_mark = 60;
  int                 cmds_taken = 0;
  int                 fault_count = 0;
  int                 cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic res_t predict_stack(cmd_t cmd, logic signed [31:0] value);
    res_t r;
    bit   found;
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    case (cmd)
      CMD_PUSH: begin
        if (model_count >= STACK_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          model_words[model_count] = value;
          model_count++;
        end
      end
      CMD_POP: begin
        if (model_count == 0) r.status = ST_UNDERFLOW;
        else model_count--;
      end
      CMD_PEEK: begin
        if (model_count == 0) r.status = ST_UNDERFLOW;
        else r.data = model_words[model_count - 1];
      end
      default: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < model_count; i++) begin
          if (!found && model_words[i] == value) begin
            found = 1'b1;
            r.status = ST_OK;
            r.data = value;
            r.index = i[INDEX_W-1:0];
          end
        end
      end
    endcase
    r.count = model_count[COUNT_W-1:0];
    r.full = (model_count == STACK_DEPTH);
    r.empty = (model_count == 0);
    return r;
  endfunction

  function automatic logic signed [31:0] pick_word();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0, 1, 2, 3, 4: return $urandom;
      5: begin
        case ($urandom_range(0, 3))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom_range(0, 7)) - 32'sd4;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_key();
    if (gen_words.size() != 0 && $urandom_range(0, 3) != 0)
      return gen_words[$urandom_range(0, gen_words.size() - 1)];
    return pick_word();
  endfunction

  task automatic add_cmd(cmd_t cmd, logic signed [31:0] value, int gap);
    stack_cmd_t c;
    c.cmd = cmd;
    c.value = value;
    c.gap = gap;
    pending_cmds.push_back(c);
    if (cmd == CMD_PUSH && gen_words.size() < STACK_DEPTH) gen_words.push_back(value);
    if (cmd == CMD_POP && gen_words.size() != 0) void'(gen_words.pop_back());
  endtask

  always @(posedge clk) begin
    stack_cmd_t c;
    if (rst) begin
      req_if.valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_results.push_back(predict_stack(cmd_t'(req_if.command), req_if.value));
        cmds_taken <= cmds_taken + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (idle_left > 0) begin
          idle_left--;
          req_if.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          c = pending_cmds.pop_front();
          req_if.valid <= 1'b1;
          req_if.command <= c.cmd;
          req_if.value <= c.value;
          idle_left = c.gap;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      next_hold_mark <= 60;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (cmds_taken >= next_hold_mark) begin
      hold_left <= LONG_HOLD;
      next_hold_mark <= next_hold_mark + 350;
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    bit   bad;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.status = status_t'(rsp_if.status);
        got.data = rsp_if.data;
        got.index = rsp_if.index;
        got.count = rsp_if.count;
        got.full = rsp_if.full_res;
        got.empty = rsp_if.empty_res;
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("Unexpected result beat: status=%0d data=%0d count=%0d",
                     got.status, got.data, got.count);
        end else begin
          want = expected_results.pop_front();
          bad = (got.status !== want.status) || (got.data !== want.data) ||
                (got.index !== want.index) || (got.count !== want.count) ||
                (got.full !== want.full) || (got.empty !== want.empty);
          if (bad) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display("Result mismatch: expected status=%0d data=%0d index=%0d count=%0d",
                       want.status, want.data, want.index, want.count);
              $display("  full=%0b empty=%0b; got status=%0d data=%0d index=%0d",
                       want.full, want.empty, got.status, got.data, got.index);
              $display("  count=%0d full=%0b empty=%0b",
                       got.count, got.full, got.empty);
            end
          end
        end
        recv_wait = (cycle_count[10:9] == 2'b00) ? 0 : $urandom_range(0, 13);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      rsp_if.ready <= (recv_wait == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("bounded_stack_with_search_unit_test failed");
      $finish;
    end
  end

  initial begin
    int  issued;
    int  len;
    int  kind;
    int  roll;
    int  gap;
    bit  calm;
    req_if.valid = 1'b0;
    req_if.command = CMD_PUSH;
    req_if.value = '0;
    rsp_if.ready = 1'b0;

    add_cmd(CMD_POP, 32'sd0, 0);
    add_cmd(CMD_PEEK, 32'sd0, 0);
    add_cmd(CMD_SEARCH, 32'sd5, 0);
    add_cmd(CMD_PUSH, WORD_MAX, 0);
    add_cmd(CMD_PUSH, WORD_MIN, 0);
    add_cmd(CMD_PUSH, 32'sd0, 0);
    add_cmd(CMD_PUSH, -32'sd1, 0);
    add_cmd(CMD_PEEK, 32'sd0, 0);
    add_cmd(CMD_SEARCH, WORD_MIN, 0);
    add_cmd(CMD_SEARCH, WORD_MAX, 0);
    add_cmd(CMD_SEARCH, 32'sd12345, 0);
    add_cmd(CMD_PUSH, WORD_MIN, 0);
    add_cmd(CMD_SEARCH, WORD_MIN, 0);
    add_cmd(CMD_SEARCH, -32'sd1, 0);
    add_cmd(CMD_POP, 32'sd0, 0);
    add_cmd(CMD_PEEK, 32'sd0, 0);
    add_cmd(CMD_PUSH, 32'sh5555_5555, 0);
    add_cmd(CMD_PUSH, 32'shAAAA_AAAA, 0);
    add_cmd(CMD_SEARCH, 32'shAAAA_AAAA, 0);
    add_cmd(CMD_SEARCH, 32'sd0, 0);
    add_cmd(CMD_POP, 32'sd0, 0);

    issued = 0;
    kind = 0;
    while (issued < RANDOM_CMDS) begin
      calm = ($urandom_range(0, 2) == 0);
      len = (issued == 0) ? 45 : $urandom_range(20, 60);
      for (int k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        gap = calm ? 0 : $urandom_range(0, 13);
        case (kind)
          0: begin
            if (roll < 80) add_cmd(CMD_PUSH, pick_word(), gap);
            else if (roll < 90) add_cmd(CMD_SEARCH, pick_key(), gap);
            else if (roll < 95) add_cmd(CMD_PEEK, pick_word(), gap);
            else add_cmd(CMD_POP, pick_word(), gap);
          end
          1: begin
            if (roll < 70) add_cmd(CMD_POP, pick_word(), gap);
            else if (roll < 80) add_cmd(CMD_PEEK, pick_word(), gap);
            else if (roll < 90) add_cmd(CMD_SEARCH, pick_key(), gap);
            else add_cmd(CMD_PUSH, pick_word(), gap);
          end
          2: begin
            if (roll < 35) add_cmd(CMD_PUSH, pick_word(), gap);
            else if (roll < 60) add_cmd(CMD_POP, pick_word(), gap);
            else if (roll < 75) add_cmd(CMD_PEEK, pick_word(), gap);
            else add_cmd(CMD_SEARCH, pick_key(), gap);
          end
          default: begin
            if (roll < 60) add_cmd(CMD_SEARCH, pick_key(), gap);
            else if (roll < 80) add_cmd(CMD_PUSH, pick_word(), gap);
            else if (roll < 90) add_cmd(CMD_POP, pick_word(), gap);
            else add_cmd(CMD_PEEK, pick_word(), gap);
          end
        endcase
        issued++;
      end
      kind = $urandom_range(0, 3);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || req_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (STACK_DEPTH + 8) @(posedge clk);

    if (fault_count == 0) begin
      $display("bounded_stack_with_search_unit_test passed");
    end else begin
      $display("bounded_stack_with_search_unit_test failed");
    end
    $finish;
  end
endmodule
